// ===== rtl/asd_pkg.sv =====
// asd_pkg: shared constants, item structs and configuration defaults
// for the accelerometer step detector; depends on nothing else
package asd_pkg;

    // calibration length in read attempts
    localparam int CALIB_SAMPLES = 20;

    // field widths
    localparam int AXIS_W = 16;
    localparam int TIME_W = 32;
    localparam int MAG_W = 32;
    localparam int BASE_W = 32;
    localparam int TH_W = BASE_W + 1;
    localparam int STEP_W = 32;
    localparam int INTV_W = 16;
    localparam int SHIFT_W = 4;

    // calibration counter and remainder widths
    localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
    localparam int REM_W = $clog2(2 * CALIB_SAMPLES);

    // reciprocal for exact floor(mag / CALIB_SAMPLES) on 32 bit values
    localparam int DIV_L = $clog2(CALIB_SAMPLES);
    localparam int DIV_SHIFT = MAG_W + DIV_L;
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(
        ((PROD_W'(1) << DIV_SHIFT) + PROD_W'(CALIB_SAMPLES) - PROD_W'(1))
        / PROD_W'(CALIB_SAMPLES));

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_SHIFT = 2'd2;

    localparam logic [INTV_W-1:0] MIN_INTERVAL_RST = 16'd250;
    localparam logic [SHIFT_W-1:0] HIGH_SHIFT_RST = 4'd4;
    localparam logic [SHIFT_W-1:0] LOW_SHIFT_RST = 4'd6;

    typedef struct packed {
        logic [INTV_W-1:0]  min_interval;
        logic [SHIFT_W-1:0] high_shift;
        logic [SHIFT_W-1:0] low_shift;
    } cfg_t;

    // raw read attempt
    typedef struct packed {
        logic                     read_ok;
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic [TIME_W-1:0]        time_now;
    } raw_item_t;

    // item after magnitude
    typedef struct packed {
        logic              read_ok;
        logic [TIME_W-1:0] time_now;
        logic [MAG_W-1:0]  mag;
    } mag_item_t;

    // item after division by the calibration length
    typedef struct packed {
        logic              read_ok;
        logic [TIME_W-1:0] time_now;
        logic [MAG_W-1:0]  mag;
        logic [MAG_W-1:0]  quot;
        logic [REM_W-1:0]  rem;
    } div_item_t;

endpackage

// ===== rtl/asd_mag.sv =====
// asd_mag: two stage squared magnitude (axis squares, then sum)
// depends on asd_pkg
module asd_mag (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  asd_pkg::raw_item_t  in_item,
    output logic                in_stall,
    output logic                out_valid,
    output asd_pkg::mag_item_t  out_item,
    input  logic                out_stall
);

    logic                          sq_valid_reg;
    logic                          sq_stall;
    logic                          sq_ok_reg;
    logic [asd_pkg::TIME_W-1:0]    sq_time_reg;
    logic [asd_pkg::MAG_W-1:0]     sq_x_reg;
    logic [asd_pkg::MAG_W-1:0]     sq_y_reg;
    logic [asd_pkg::MAG_W-1:0]     sq_z_reg;
    logic signed [asd_pkg::MAG_W-1:0] sq_x_next;
    logic signed [asd_pkg::MAG_W-1:0] sq_y_next;
    logic signed [asd_pkg::MAG_W-1:0] sq_z_next;

    logic                          mag_valid_reg;
    logic                          mag_stall;
    asd_pkg::mag_item_t            mag_reg;
    logic [asd_pkg::MAG_W-1:0]     mag_next;

    assign mag_stall = mag_valid_reg && out_stall;
    assign sq_stall  = sq_valid_reg && mag_stall;
    assign in_stall  = sq_stall;

    // squares of signed axes are never negative
    assign sq_x_next = in_item.accel_x * in_item.accel_x;
    assign sq_y_next = in_item.accel_y * in_item.accel_y;
    assign sq_z_next = in_item.accel_z * in_item.accel_z;

    // failed read gives zero magnitude
    assign mag_next = sq_ok_reg ? (sq_x_reg + sq_y_reg + sq_z_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            mag_valid_reg <= 1'b0;
        end
        else
        begin
            if (!sq_stall)
            begin
                sq_valid_reg <= in_valid;
            end
            if (!mag_stall)
            begin
                mag_valid_reg <= sq_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !sq_stall)
        begin
            sq_ok_reg   <= in_item.read_ok;
            sq_time_reg <= in_item.time_now;
            sq_x_reg    <= $unsigned(sq_x_next);
            sq_y_reg    <= $unsigned(sq_y_next);
            sq_z_reg    <= $unsigned(sq_z_next);
        end
        if (sq_valid_reg && !mag_stall)
        begin
            mag_reg.read_ok  <= sq_ok_reg;
            mag_reg.time_now <= sq_time_reg;
            mag_reg.mag      <= mag_next;
        end
    end

    assign out_valid = mag_valid_reg;
    assign out_item  = mag_reg;

endmodule

// ===== rtl/asd_div.sv =====
// asd_div: two stage constant divide of the magnitude by the calibration
// length (reciprocal multiply, then remainder); depends on asd_pkg
module asd_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  asd_pkg::mag_item_t  in_item,
    output logic                in_stall,
    output logic                out_valid,
    output asd_pkg::div_item_t  out_item,
    input  logic                out_stall
);

    logic                          q_valid_reg;
    logic                          q_stall;
    asd_pkg::mag_item_t            q_item_reg;
    logic [asd_pkg::MAG_W-1:0]     q_reg;
    logic [asd_pkg::PROD_W-1:0]    prod;
    logic [asd_pkg::MAG_W-1:0]     q_next;

    logic                          r_valid_reg;
    logic                          r_stall;
    asd_pkg::div_item_t            r_reg;
    logic [asd_pkg::MAG_W-1:0]     r_full;
    logic [asd_pkg::REM_W-1:0]     r_next;

    assign r_stall  = r_valid_reg && out_stall;
    assign q_stall  = q_valid_reg && r_stall;
    assign in_stall = q_stall;

    assign prod   = asd_pkg::PROD_W'(in_item.mag) * asd_pkg::PROD_W'(asd_pkg::DIV_RECIP);
    assign q_next = asd_pkg::MAG_W'(prod >> asd_pkg::DIV_SHIFT);

    // remainder is below the divisor
    assign r_full = q_item_reg.mag
                  - asd_pkg::MAG_W'(q_reg * asd_pkg::MAG_W'(asd_pkg::CALIB_SAMPLES));
    assign r_next = r_full[asd_pkg::REM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (!q_stall)
            begin
                q_valid_reg <= in_valid;
            end
            if (!r_stall)
            begin
                r_valid_reg <= q_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !q_stall)
        begin
            q_item_reg <= in_item;
            q_reg      <= q_next;
        end
        if (q_valid_reg && !r_stall)
        begin
            r_reg.read_ok  <= q_item_reg.read_ok;
            r_reg.time_now <= q_item_reg.time_now;
            r_reg.mag      <= q_item_reg.mag;
            r_reg.quot     <= q_reg;
            r_reg.rem      <= r_next;
        end
    end

    assign out_valid = r_valid_reg;
    assign out_item  = r_reg;

endmodule

// ===== rtl/asd_track.sv =====
// asd_track: calibration accumulator, hysteresis detector, step counter
// and the result register; depends on asd_pkg
module asd_track (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  asd_pkg::div_item_t          in_item,
    output logic                        in_stall,
    input  asd_pkg::cfg_t               cfg,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [asd_pkg::STEP_W-1:0]  steps_total,
    output logic                        step_taken,
    output logic                        calibrated,
    output logic [asd_pkg::MAG_W-1:0]   magnitude_sq
);

    localparam logic [asd_pkg::CNT_W-1:0] SEEN_DONE = asd_pkg::CNT_W'(asd_pkg::CALIB_SAMPLES);
    localparam logic [asd_pkg::REM_W-1:0] REM_DIV = asd_pkg::REM_W'(asd_pkg::CALIB_SAMPLES);

    logic                           out_valid_reg;
    logic                           take;

    // state
    logic [asd_pkg::CNT_W-1:0]      seen_reg, seen_next;
    logic [asd_pkg::BASE_W-1:0]     base_reg, base_next;
    logic [asd_pkg::REM_W-1:0]      rem_acc_reg, rem_acc_next;
    logic [asd_pkg::SHIFT_W-1:0]    hs_reg, hs_next;
    logic [asd_pkg::SHIFT_W-1:0]    ls_reg, ls_next;
    logic                           armed_reg, armed_next;
    logic [asd_pkg::TIME_W-1:0]     last_reg, last_next;
    logic [asd_pkg::STEP_W-1:0]     total_reg, total_next;

    // result payload
    logic                           took_reg, took_next;
    logic [asd_pkg::MAG_W-1:0]      mag_out_reg;

    logic                           calibrating;
    logic [asd_pkg::REM_W-1:0]      rem_sum;
    logic                           carry;
    logic [asd_pkg::TH_W-1:0]       arm_th;
    logic [asd_pkg::TH_W-1:0]       disarm_th;
    logic [asd_pkg::TH_W-1:0]       mag_ext;
    logic                           armed_mid;
    logic [asd_pkg::TIME_W-1:0]     gap;

    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    assign calibrating = seen_reg < SEEN_DONE;
    assign rem_sum     = rem_acc_reg + in_item.rem;
    assign carry       = rem_sum >= REM_DIV;

    // thresholds from the stored base and the shifts captured at calibration end
    assign arm_th    = asd_pkg::TH_W'(base_reg) + asd_pkg::TH_W'(base_reg >> hs_reg);
    assign disarm_th = asd_pkg::TH_W'(base_reg) + asd_pkg::TH_W'(base_reg >> ls_reg);
    assign mag_ext   = asd_pkg::TH_W'(in_item.mag);
    assign armed_mid = armed_reg || (mag_ext > arm_th);
    assign gap       = in_item.time_now - last_reg;

    always_comb
    begin
        seen_next    = seen_reg;
        base_next    = base_reg;
        rem_acc_next = rem_acc_reg;
        hs_next      = hs_reg;
        ls_next      = ls_reg;
        armed_next   = armed_reg;
        last_next    = last_reg;
        total_next   = total_reg;
        took_next    = 1'b0;
        if (calibrating)
        begin
            // sum kept as quotient and remainder; failed reads carry zeros
            rem_acc_next = carry ? (rem_sum - REM_DIV) : rem_sum;
            base_next    = base_reg + in_item.quot + asd_pkg::BASE_W'(carry);
            seen_next    = seen_reg + 1'b1;
            if (seen_next == SEEN_DONE)
            begin
                hs_next = cfg.high_shift;
                ls_next = cfg.low_shift;
            end
        end
        else if (in_item.read_ok)
        begin
            armed_next = armed_mid;
            if (armed_mid && (mag_ext < disarm_th))
            begin
                armed_next = 1'b0;
                if (gap >= asd_pkg::TIME_W'(cfg.min_interval))
                begin
                    total_next = total_reg + 1'b1;
                    last_next  = in_item.time_now;
                    took_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            base_reg      <= '0;
            rem_acc_reg   <= '0;
            hs_reg        <= asd_pkg::HIGH_SHIFT_RST;
            ls_reg        <= asd_pkg::LOW_SHIFT_RST;
            armed_reg     <= 1'b0;
            last_reg      <= '0;
            total_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                out_valid_reg <= in_valid;
            end
            if (take)
            begin
                seen_reg    <= seen_next;
                base_reg    <= base_next;
                rem_acc_reg <= rem_acc_next;
                hs_reg      <= hs_next;
                ls_reg      <= ls_next;
                armed_reg   <= armed_next;
                last_reg    <= last_next;
                total_reg   <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            took_reg    <= took_next;
            mag_out_reg <= in_item.mag;
        end
    end

    // state only moves when a new result loads, so it doubles as result data
    assign out_valid    = out_valid_reg;
    assign steps_total  = total_reg;
    assign calibrated   = !calibrating;
    assign step_taken   = took_reg;
    assign magnitude_sq = mag_out_reg;

endmodule

// ===== rtl/accel_step_detector.sv =====
// accel_step_detector: top level of the accelerometer step counter
// depends on asd_pkg, asd_mag, asd_div, asd_track
//
// channel   direction  handshake             payload
// ------    ---------  --------------------  -------------------------------------------
// input     in         in_valid / in_stall   read_ok, accel_x/y/z, time_now
// output    out        out_valid / out_stall steps_total, step_taken, calibrated,
//                                            magnitude_sq
// config    in         cfg_we                cfg_index, cfg_data
//
// one item per clock sustained while out_stall is low, exactly one result per item
// from acceptance to out_valid an item passes the input register, axis squares,
//   magnitude sum, reciprocal multiply, remainder, then state update into the result
// each stage holds its item only while the one after it is full and stalled,
//   so in_stall rises only when every stage is full and out_stall is high
// reset clears the pipeline valids and all detector state; config returns to
//   min_interval 250, high_shift 4, low_shift 6
module accel_step_detector (
    input  logic                                clk,
    input  logic                                rst_n,

    // input item channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                read_ok,
    input  logic signed [asd_pkg::AXIS_W-1:0]   accel_x,
    input  logic signed [asd_pkg::AXIS_W-1:0]   accel_y,
    input  logic signed [asd_pkg::AXIS_W-1:0]   accel_z,
    input  logic [asd_pkg::TIME_W-1:0]          time_now,

    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [asd_pkg::STEP_W-1:0]          steps_total,
    output logic                                step_taken,
    output logic                                calibrated,
    output logic [asd_pkg::MAG_W-1:0]           magnitude_sq,

    // configuration write port
    input  logic                                cfg_we,
    input  logic [asd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration registers
    asd_pkg::cfg_t          cfg_reg;

    // input register stage
    logic                   in_valid_reg;
    asd_pkg::raw_item_t     in_item_reg;
    logic                   mag_in_stall;

    // stage links
    logic                   mag_valid;
    asd_pkg::mag_item_t     mag_item;
    logic                   div_in_stall;
    logic                   div_valid;
    asd_pkg::div_item_t     div_item;
    logic                   trk_in_stall;

    // register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_interval <= asd_pkg::MIN_INTERVAL_RST;
            cfg_reg.high_shift   <= asd_pkg::HIGH_SHIFT_RST;
            cfg_reg.low_shift    <= asd_pkg::LOW_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                asd_pkg::CFG_MIN_INTERVAL:
                begin
                    cfg_reg.min_interval <= cfg_data[asd_pkg::INTV_W-1:0];
                end
                asd_pkg::CFG_HIGH_SHIFT:
                begin
                    cfg_reg.high_shift <= cfg_data[asd_pkg::SHIFT_W-1:0];
                end
                asd_pkg::CFG_LOW_SHIFT:
                begin
                    cfg_reg.low_shift <= cfg_data[asd_pkg::SHIFT_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // input register: takes a new item whenever the next stage can move
    assign in_stall = in_valid_reg && mag_in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg.read_ok  <= read_ok;
            in_item_reg.accel_x  <= accel_x;
            in_item_reg.accel_y  <= accel_y;
            in_item_reg.accel_z  <= accel_z;
            in_item_reg.time_now <= time_now;
        end
    end

    // squared magnitude
    asd_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_item   (in_item_reg),
        .in_stall  (mag_in_stall),
        .out_valid (mag_valid),
        .out_item  (mag_item),
        .out_stall (div_in_stall)
    );

    // magnitude split into quotient and remainder by the calibration length
    asd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mag_valid),
        .in_item   (mag_item),
        .in_stall  (div_in_stall),
        .out_valid (div_valid),
        .out_item  (div_item),
        .out_stall (trk_in_stall)
    );

    // calibration, hysteresis detection and result register
    asd_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (div_valid),
        .in_item      (div_item),
        .in_stall     (trk_in_stall),
        .cfg          (cfg_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .steps_total  (steps_total),
        .step_taken   (step_taken),
        .calibrated   (calibrated),
        .magnitude_sq (magnitude_sq)
    );

`ifndef ASSERT_OFF
    // a step is only ever counted once thresholds exist
    a_step_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_taken |-> calibrated)
        else $error("step counted before calibration");

    // no steps can accumulate during calibration
    a_no_steps_uncal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !calibrated |-> steps_total == '0)
        else $error("steps counted during calibration");

    // back-pressure reaches the input only from a stalled, full result register
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");
`endif

endmodule
